// File: rtl/assert_macros.svh
// Assertion macros shared by the walk loop erasure RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge while reset is released.
`define WLE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a trigger is followed by a condition in the next cycle.
`define WLE_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);
`else
`define WLE_ASSERT(lbl, clk, rst_n, prop, msg)
`define WLE_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg)
`endif
`endif

// File: rtl/wle_pkg.sv
// Package with sizes, types and sequencer states of the walk loop erasure block.
`timescale 1ns / 1ps
package wle_pkg;

	localparam int MAX_TRAIL = 64;
	localparam int VERTEX_W  = 10;
	localparam int INDEX_W   = 6;
	localparam int PTR_W     = (MAX_TRAIL > 1) ? $clog2(MAX_TRAIL) : 1;
	localparam int CNT_W     = $clog2(MAX_TRAIL + 1);

	typedef logic [VERTEX_W-1:0] vertex_t;
	typedef logic [PTR_W-1:0]    ptr_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [INDEX_W-1:0]  index_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_HEAD_RD,
		ST_HEAD_CAP,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic    we;
		ptr_t    waddr;
		vertex_t wdata;
		logic    re;
		ptr_t    raddr;
	} mem_req_t;

endpackage

// File: rtl/wle_walk_if.sv
// Channel carrying walk vertices into the block.
`timescale 1ns / 1ps
interface wle_walk_if;
	logic                      valid;
	logic                      ready;
	logic [wle_pkg::VERTEX_W-1:0] walk_vertex;
	logic                      walk_end;

	modport source (output valid, output walk_vertex, output walk_end, input ready);
	modport sink   (input valid, input walk_vertex, input walk_end, output ready);
endinterface

// File: rtl/wle_path_if.sv
// Channel carrying loop-erased path vertices out of the block.
`timescale 1ns / 1ps
interface wle_path_if;
	logic                         valid;
	logic                         ready;
	logic [wle_pkg::VERTEX_W-1:0] path_vertex;
	logic [wle_pkg::INDEX_W-1:0]  path_index;
	logic                         path_last;
	logic                         walk_overflow;

	modport source (output valid, output path_vertex, output path_index, output path_last,
		output walk_overflow, input ready);
	modport sink   (input valid, input path_vertex, input path_index, input path_last,
		input walk_overflow, output ready);
endinterface

// File: rtl/wle_trail_mem.sv
// Trail memory: one write port, one registered read port.
`timescale 1ns / 1ps
module wle_trail_mem (
	input  logic              clk,
	input  wle_pkg::mem_req_t req,
	output wle_pkg::vertex_t  rd_data
);

	wle_pkg::vertex_t mem [wle_pkg::MAX_TRAIL];
	wle_pkg::vertex_t rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem[req.raddr];
		end
	end

	assign rd_data = rd_q;

endmodule

// File: rtl/wle_seq.sv
// Sequencer and shared compare unit that load the trail and erase its loops.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wle_seq (
	input  logic               clk,
	input  logic               arst_n,
	wle_walk_if.sink           walk,
	wle_path_if.source         path,
	output wle_pkg::mem_req_t  mem_req,
	input  wle_pkg::vertex_t   rd_data
);

	wle_pkg::state_t  st_q, st_nxt;
	wle_pkg::cnt_t    cnt_q;
	logic             ovf_q;
	wle_pkg::cnt_t    pos_q;
	wle_pkg::cnt_t    k_q;
	wle_pkg::cnt_t    last_q;
	wle_pkg::vertex_t v_q;
	wle_pkg::index_t  n_q;
	logic             out_vld_q;
	wle_pkg::vertex_t out_vertex_q;
	wle_pkg::index_t  out_index_q;
	logic             out_last_q;
	logic             out_ovf_q;

	logic             walk_beat;
	logic             has_room;
	logic             load_out;
	logic             fin;
	wle_pkg::cnt_t    k_nx;
	wle_pkg::cnt_t    last_nx;

	assign walk_beat = walk.valid && walk.ready;
	assign has_room  = cnt_q < wle_pkg::CNT_W'(wle_pkg::MAX_TRAIL);
	assign k_nx      = k_q + wle_pkg::CNT_W'(1);
	assign last_nx   = last_q + wle_pkg::CNT_W'(1);
	assign fin       = last_nx >= cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= wle_pkg::ST_LOAD;
		end else begin
			st_q <= st_nxt;
		end
	end

	always_comb begin
		st_nxt        = st_q;
		walk.ready    = 1'b0;
		load_out      = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = cnt_q[wle_pkg::PTR_W-1:0];
		mem_req.wdata = walk.walk_vertex;
		mem_req.re    = 1'b0;
		mem_req.raddr = pos_q[wle_pkg::PTR_W-1:0];
		unique case (st_q)
			wle_pkg::ST_LOAD: begin
				walk.ready = 1'b1;
				mem_req.we = walk.valid && has_room;
				if (walk.valid && walk.walk_end) begin
					st_nxt = wle_pkg::ST_HEAD_RD;
				end
			end
			wle_pkg::ST_HEAD_RD: begin
				mem_req.re = 1'b1;
				st_nxt     = wle_pkg::ST_HEAD_CAP;
			end
			wle_pkg::ST_HEAD_CAP: begin
				st_nxt = (k_q < cnt_q) ? wle_pkg::ST_SCAN_RD : wle_pkg::ST_EMIT;
			end
			wle_pkg::ST_SCAN_RD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = k_q[wle_pkg::PTR_W-1:0];
				st_nxt        = wle_pkg::ST_SCAN_CMP;
			end
			wle_pkg::ST_SCAN_CMP: begin
				st_nxt = (k_nx < cnt_q) ? wle_pkg::ST_SCAN_RD : wle_pkg::ST_EMIT;
			end
			wle_pkg::ST_EMIT: begin
				load_out = !out_vld_q || path.ready;
				if (load_out) begin
					st_nxt = fin ? wle_pkg::ST_LOAD : wle_pkg::ST_HEAD_RD;
				end
			end
			default: begin
				st_nxt = wle_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			pos_q     <= '0;
			n_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (path.ready) begin
				out_vld_q <= 1'b0;
			end
			if (st_q == wle_pkg::ST_LOAD && walk_beat) begin
				// drop vertices once the trail is full
				if (has_room) begin
					cnt_q <= cnt_q + wle_pkg::CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				if (walk.walk_end) begin
					pos_q <= '0;
					n_q   <= '0;
				end
			end
			if (load_out) begin
				n_q   <= n_q + wle_pkg::INDEX_W'(1);
				pos_q <= last_nx;
				if (fin) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			wle_pkg::ST_HEAD_RD: begin
				last_q <= pos_q;
				k_q    <= pos_q + wle_pkg::CNT_W'(1);
			end
			wle_pkg::ST_HEAD_CAP: begin
				v_q <= rd_data;
			end
			wle_pkg::ST_SCAN_CMP: begin
				// keep the latest position holding the head vertex
				if (rd_data == v_q) begin
					last_q <= k_q;
				end
				k_q <= k_nx;
			end
			wle_pkg::ST_EMIT: begin
				if (load_out) begin
					out_vertex_q <= v_q;
					out_index_q  <= n_q;
					out_last_q   <= fin;
					out_ovf_q    <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign path.valid         = out_vld_q;
	assign path.path_vertex   = out_vertex_q;
	assign path.path_index    = out_index_q;
	assign path.path_last     = out_last_q;
	assign path.walk_overflow = out_ovf_q;

	`WLE_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= wle_pkg::CNT_W'(wle_pkg::MAX_TRAIL), "trail count above capacity")
	`WLE_ASSERT(a_scan_in_trail, clk, arst_n, (st_q != wle_pkg::ST_SCAN_RD) || (k_q < cnt_q), "scan read past trail end")
	`WLE_ASSERT(a_emit_span, clk, arst_n, (st_q != wle_pkg::ST_EMIT) || (last_q < cnt_q && pos_q <= last_q), "emit with bad loop span")
	`WLE_ASSERT_NEXT(a_clear_after_last, clk, arst_n, load_out && fin, cnt_q == '0 && !ovf_q && st_q == wle_pkg::ST_LOAD, "trail not cleared after final path vertex")

endmodule

// File: rtl/walk_loop_erasure_core.sv
// Top level of the chronological loop erasure block for random walks.
//
// Channel walk (sink): one beat per walk vertex; walk_end marks the final one.
// Vertices are stored in a trail memory of MAX_TRAIL entries; once it is full,
// further vertices are dropped and walk_overflow is set on every path beat.
// Channel path (source): one beat per vertex of the loop-erased path, with
// path_index from 0 and path_last on the final one.
// Loading accepts one vertex per cycle. After walk_end, each path vertex is
// fetched by reading its head entry and capturing it, then each trail entry
// behind it is read in turn and compared with the head, and the vertex is
// then emitted. The trail memory has a single read port and the block uses
// one equality comparator for the whole scan. walk is not ready during
// erasure; it is ready again in the cycle after the final path beat is loaded.
// Results sit in an output register; a stalled receiver holds the erasure at
// its next emit until the beat is taken, and loading of the next walk may
// proceed while the final beat still waits.
// Reset clears the trail count, the overflow flag and the output valid.
`timescale 1ns / 1ps
module walk_loop_erasure_core (
	input  logic       clk,
	input  logic       arst_n,
	wle_walk_if.sink   walk,
	wle_path_if.source path
);

	wle_pkg::mem_req_t mem_req;
	wle_pkg::vertex_t  rd_data;

	wle_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.walk    (walk),
		.path    (path),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	wle_trail_mem u_trail_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

endmodule

// File: test/tb_top.sv
// Testbench for walk_loop_erasure_core: random walks in, erased paths checked beat by beat.
`timescale 1ns / 1ps
module tb_top;

	localparam int DIRECTED_ITEMS = 24;
	localparam int RANDOM_ITEMS   = 236;
	localparam int QUIET_ITEMS    = 40;
	// worst walks cost the most erasure; this limit is many times the slowest run
	localparam int RUN_LIMIT      = 1000000;
	localparam int TAIL_CYCLES    = 200;

	typedef struct packed {
		wle_pkg::vertex_t path_vertex;
		wle_pkg::index_t  path_index;
		logic             path_last;
		logic             walk_overflow;
	} path_beat_t;

	class erasure_board;
		wle_pkg::vertex_t trail[wle_pkg::MAX_TRAIL];
		int unsigned trail_len;
		bit         dropped;
		path_beat_t expected_path[$];
		int         errors;

		// Store one walk vertex; on the final one, erase loops and queue the path.
		function void note_vertex(wle_pkg::vertex_t v, logic at_end);
			int unsigned pos;
			int unsigned last_pos;
			int unsigned n;
			path_beat_t b;
			if (trail_len < wle_pkg::MAX_TRAIL) begin
				trail[trail_len] = v;
				trail_len++;
			end else begin
				dropped = 1'b1;
			end
			if (!at_end)
				return;
			pos = 0;
			n = 0;
			while (pos < trail_len) begin
				last_pos = pos;
				for (int unsigned k = pos; k < trail_len; k++)
					if (trail[k] == trail[pos])
						last_pos = k;
				b.path_vertex   = trail[pos];
				b.path_index    = wle_pkg::index_t'(n);
				b.path_last     = (last_pos + 1 >= trail_len);
				b.walk_overflow = dropped;
				expected_path.push_back(b);
				n++;
				pos = last_pos + 1;
			end
			trail_len = 0;
			dropped = 1'b0;
		endfunction

		function void check_beat(path_beat_t got);
			path_beat_t want;
			if (expected_path.size() == 0) begin
				$display("%0t: unexpected path beat vertex=%0d index=%0d last=%0b ovf=%0b",
					$time, got.path_vertex, got.path_index, got.path_last, got.walk_overflow);
				errors++;
				return;
			end
			want = expected_path.pop_front();
			if (got !== want) begin
				$display("%0t: path beat mismatch expected vertex=%0d index=%0d last=%0b ovf=%0b",
					$time, want.path_vertex, want.path_index, want.path_last,
					want.walk_overflow);
				$display("%0t:                   actual   vertex=%0d index=%0d last=%0b ovf=%0b",
					$time, got.path_vertex, got.path_index, got.path_last, got.walk_overflow);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	wle_walk_if walk_ch ();
	wle_path_if path_ch ();

	erasure_board board = new();
	int  sent_vertices;
	bit  quiet;
	int  cycle_count;
	int  stall_left;

	walk_loop_erasure_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.walk   (walk_ch),
		.path   (path_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Receiver: random stall bursts, none once the run goes quiet.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			path_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			path_ch.ready <= 1'b1;
			if (!quiet && $urandom_range(0, 9) == 0)
				stall_left <= $urandom_range(1, 14);
		end
	end

	// Values are stable at the falling edge; a beat seen here is taken at the next rising edge.
	always @(negedge clk) begin
		path_beat_t got;
		if (arst_n === 1'b1 && path_ch.valid === 1'b1 && path_ch.ready === 1'b1) begin
			got = '{path_ch.path_vertex, path_ch.path_index, path_ch.path_last,
				path_ch.walk_overflow};
			board.check_beat(got);
		end
	end

	// Called at a rising edge; returns at the rising edge where the beat is taken.
	task automatic send_vertex(input wle_pkg::vertex_t v, input logic at_end);
		walk_ch.valid       <= 1'b1;
		walk_ch.walk_vertex <= v;
		walk_ch.walk_end    <= at_end;
		do
			@(negedge clk);
		while (walk_ch.ready !== 1'b1);
		@(posedge clk);
		board.note_vertex(v, at_end);
		sent_vertices++;
	endtask

	task automatic idle_walk(input int cycles);
		walk_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_path_drained();
		walk_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.expected_path.size() != 0)
			@(posedge clk);
	endtask

	// Vertices drawn from a narrow window make loops common; wide draws cover all bits.
	task automatic send_walk(input int len, input bit wide);
		int span;
		int base;
		wle_pkg::vertex_t v;
		span = $urandom_range(1, 7);
		base = $urandom_range(0, 1023 - span);
		for (int i = 0; i < len; i++) begin
			if (!quiet && $urandom_range(0, 5) == 0)
				idle_walk($urandom_range(1, 14));
			v = wide ? wle_pkg::vertex_t'($urandom_range(0, 1023)) :
				wle_pkg::vertex_t'(base + $urandom_range(0, span));
			send_vertex(v, i == len - 1);
		end
	endtask

	initial begin
		int unsigned directed_v[DIRECTED_ITEMS];
		bit          directed_e[DIRECTED_ITEMS];
		int          walk_num;
		int          len;
		directed_v = '{0, 1023, 5, 5, 5, 1, 2, 3, 1, 7, 8, 7, 9, 10, 11, 12, 11, 13,
			0, 1023, 0, 1023, 682, 341};
		directed_e = '{1, 1, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 1,
			0, 0, 0, 1, 0, 1};
		arst_n = 1'b0;
		walk_ch.valid       <= 1'b0;
		walk_ch.walk_vertex <= '0;
		walk_ch.walk_end    <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single vertex, repeated vertex, loop back to start, two loops in sequence, alternating bits
		foreach (directed_v[i])
			send_vertex(wle_pkg::vertex_t'(directed_v[i]), directed_e[i]);
		wait_path_drained();

		walk_num = 0;
		while (sent_vertices < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			if (sent_vertices >= DIRECTED_ITEMS + RANDOM_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			// trail exactly full, end vertex dropped, long overflow
			case (walk_num)
				2: len = wle_pkg::MAX_TRAIL;
				5: len = wle_pkg::MAX_TRAIL + 1;
				8: len = wle_pkg::MAX_TRAIL + 6;
				default: len = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 72) :
					$urandom_range(1, 12);
			endcase
			send_walk(len, $urandom_range(0, 3) == 0);
			if (!quiet && $urandom_range(0, 7) == 0)
				wait_path_drained();
			walk_num++;
		end

		wait_path_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
